>>> sv/ies_pkg.sv
// Shared types and constants of the IR emitter scan and distance block
package ies_pkg;

  localparam int NUM_W      = 24;
  localparam int RAW_W      = 10;
  localparam int SAMPLE_W   = 10;
  localparam int MASK_W     = 4;
  localparam int IDX_W      = 2;
  localparam int DIST_W     = 20;
  localparam int FRAC_SHIFT = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [NUM_W-1:0]  NUM_RESET     = 24'd705606;
  localparam logic [RAW_W-1:0]  MIN_RAW_RESET = 10'd2;
  localparam logic [DIST_W-1:0] Q8_MAX        = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAW   = 1'b1;

  // Request commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_CONV = 1'b1;

  // Scan phase of the current sensor
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_READ = 3'b100
  } phase_t;

  // One result request
  typedef struct packed {
    logic [MASK_W-1:0] emitter_mask;
    logic              start_conversion;
    logic              distance_valid;
    logic [IDX_W-1:0]  sensor_index;
    logic [DIST_W-1:0] distance_q8;
    logic              distance_infinite;
  } res_t;

endpackage

>>> sv/ies_chan_if.sv
// Request and result channel interfaces of the IR emitter scan block
interface ies_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic                          enable;
  logic [ies_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, cmd, enable, sample, input ready);
  modport sink   (input valid, cmd, enable, sample, output ready);
endinterface

interface ies_out_if;
  logic                          valid;
  logic                          ready;
  logic [ies_pkg::MASK_W-1:0]    emitter_mask;
  logic                          start_conversion;
  logic                          distance_valid;
  logic [ies_pkg::IDX_W-1:0]     sensor_index;
  logic [ies_pkg::DIST_W-1:0]    distance_q8;
  logic                          distance_infinite;

  modport source (output valid, emitter_mask, start_conversion, distance_valid,
                  sensor_index, distance_q8, distance_infinite, input ready);
  modport sink   (input valid, emitter_mask, start_conversion, distance_valid,
                  sensor_index, distance_q8, distance_infinite, output ready);
endinterface

>>> sv/ies_div.sv
// Restoring divider, one quotient bit per cycle
module ies_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  // Bring down the next dividend bit and try the subtract
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold the operands and partial results
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/ies_sqrt.sv
// Integer square root, one root bit per cycle
module ies_sqrt #(
  parameter int RAD_W = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);

  localparam int R_W   = RAD_W / 2;
  localparam int CNT_W = $clog2(R_W + 1);

  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [R_W-1:0]   root_r, root_nxt;
  logic [R_W:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [R_W+2:0]   rem_sh;
  logic [R_W+2:0]   trial;
  logic [R_W+2:0]   diff;

  // Bring in the next two radicand bits and try 4*root+1
  assign rem_sh = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(R_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = diff[R_W:0];
        root_nxt = {root_r[R_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[R_W:0];
        root_nxt = {root_r[R_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold the partial root and remainder
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> sv/ir_emitter_scan_distance_top.sv
// Top level: scan sequencer, configuration registers and result register
// Results: a tick or conversion request gives its result in the cycle after acceptance,
// except a completed finite reading, which first runs through 40 divider
// steps (one quotient bit each) and then 20 square-root steps (one root bit each).
// Flow: one request at a time; a new one is taken when idle with the result register free.
// Reset (rst_n, synchronous): phase idle, sensor 0, no sample pending, registers at defaults.
module ir_emitter_scan_distance_top #(
  parameter int SENSOR_COUNT = 4,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ies_in_if.sink                          in_ch,
  ies_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ies_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ies_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DVD_W = ies_pkg::NUM_W + ies_pkg::FRAC_SHIFT;
  localparam int CMP_W = (SAMPLE_BITS > ies_pkg::RAW_W) ? SAMPLE_BITS : ies_pkg::RAW_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SQRT = 3'b100
  } seq_t;

  seq_t                          st_r, st_nxt;
  ies_pkg::phase_t               ph_r, ph_nxt;
  logic [ies_pkg::IDX_W-1:0]     cur_r, cur_nxt;
  logic                          rdy_r, rdy_nxt;
  logic [SAMPLE_BITS-1:0]        lat_r, lat_nxt;
  logic [ies_pkg::IDX_W-1:0]     pidx_r, pidx_nxt;
  logic [ies_pkg::NUM_W-1:0]     num_r;
  logic [ies_pkg::RAW_W-1:0]     min_raw_r;
  ies_pkg::res_t                 res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          in_acc;
  logic                          out_free;
  logic                          div_start;
  logic                          div_done;
  logic [DVD_W-1:0]              quo;
  logic                          sq_start;
  logic                          sq_done;
  logic [ies_pkg::DIST_W-1:0]    root;
  logic                          is_inf;
  logic [ies_pkg::IDX_W:0]       cur_inc;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && out_free;

  // Zero or too small samples give an infinite distance
  assign is_inf  = (lat_r == '0) || (CMP_W'(lat_r) < CMP_W'(min_raw_r));
  assign cur_inc = {1'b0, cur_r} + (ies_pkg::IDX_W + 1)'(1);

  // Shared iterative units
  ies_div #(.DVD_W(DVD_W), .DVS_W(SAMPLE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({num_r, {ies_pkg::FRAC_SHIFT{1'b0}}}),
    .divisor  (lat_r),
    .done     (div_done),
    .quotient (quo)
  );

  ies_sqrt #(.RAD_W(DVD_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (quo),
    .done     (sq_done),
    .root     (root)
  );

  // Sequencer: scan phases, then divide and root for a finite reading
  always_comb begin
    st_nxt        = st_r;
    ph_nxt        = ph_r;
    cur_nxt       = cur_r;
    rdy_nxt       = rdy_r;
    lat_nxt       = lat_r;
    pidx_nxt      = pidx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    sq_start      = 1'b0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          if (in_ch.cmd == ies_pkg::CMD_CONV) begin
            lat_nxt = SAMPLE_BITS'(in_ch.sample);
            rdy_nxt = 1'b1;
          end else if (!in_ch.enable) begin
            ph_nxt = ies_pkg::PH_IDLE;
          end else begin
            case (ph_r)
              ies_pkg::PH_READ: begin
                if (rdy_r) begin
                  rdy_nxt = 1'b0;
                  ph_nxt  = ies_pkg::PH_IDLE;
                  cur_nxt = (cur_inc >= (ies_pkg::IDX_W + 1)'(SENSOR_COUNT)) ?
                            '0 : cur_inc[ies_pkg::IDX_W-1:0];
                  res_nxt.distance_valid = 1'b1;
                  res_nxt.sensor_index   = cur_r;
                  if (is_inf) begin
                    res_nxt.distance_infinite = 1'b1;
                    res_nxt.distance_q8       = ies_pkg::Q8_MAX;
                  end
                end
              end
              ies_pkg::PH_WAIT: begin
                res_nxt.start_conversion = 1'b1;
                ph_nxt = ies_pkg::PH_READ;
              end
              default: begin
                ph_nxt = ies_pkg::PH_WAIT;
              end
            endcase
          end
          if (ph_nxt == ies_pkg::PH_WAIT || ph_nxt == ies_pkg::PH_READ) begin
            res_nxt.emitter_mask = ies_pkg::MASK_W'(1) << cur_nxt;
          end
          if (in_ch.cmd == ies_pkg::CMD_TICK && in_ch.enable &&
              ph_r == ies_pkg::PH_READ && rdy_r && !is_inf) begin
            // Finite reading: hand over to the divider
            div_start = 1'b1;
            pidx_nxt  = cur_r;
            st_nxt    = ST_DIV;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sq_start = 1'b1;
          st_nxt   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done && out_free) begin
          res_nxt                   = '0;
          res_nxt.distance_valid    = 1'b1;
          res_nxt.sensor_index      = pidx_r;
          res_nxt.distance_q8       = root;
          out_valid_nxt             = 1'b1;
          st_nxt                    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ph_r        <= ies_pkg::PH_IDLE;
      cur_r       <= '0;
      rdy_r       <= 1'b0;
      lat_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ph_r        <= ph_nxt;
      cur_r       <= cur_nxt;
      rdy_r       <= rdy_nxt;
      lat_r       <= lat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    pidx_r <= pidx_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r     <= ies_pkg::NUM_RESET;
      min_raw_r <= ies_pkg::MIN_RAW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ies_pkg::CFG_NUMERATOR: num_r     <= cfg_wdata[ies_pkg::NUM_W-1:0];
        ies_pkg::CFG_MIN_RAW:   min_raw_r <= cfg_wdata[ies_pkg::RAW_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.emitter_mask      = res_r.emitter_mask;
  assign out_ch.start_conversion  = res_r.start_conversion;
  assign out_ch.distance_valid    = res_r.distance_valid;
  assign out_ch.sensor_index      = res_r.sensor_index;
  assign out_ch.distance_q8       = res_r.distance_q8;
  assign out_ch.distance_infinite = res_r.distance_infinite;

`ifndef SYNTHESIS
  a_seq_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("sequencer state not one-hot");

  a_disable_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.cmd == ies_pkg::CMD_TICK && !in_ch.enable
    |=> out_ch.valid && out_ch.emitter_mask == '0)
    else $error("disable tick left an emitter on");

  a_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.distance_valid
    |-> out_ch.distance_q8 == '0 && !out_ch.distance_infinite)
    else $error("distance fields set without a reading");

  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !in_ch.ready && st_r == ST_DIV)
    else $error("request taken while dividing");
`endif

endmodule
